### rtl/hxt_pkg.sv
// hxt_pkg: shared constants, result struct and CRC / hex helper functions
// for the CRC-32 hex trailer checker. No dependencies.

package hxt_pkg;

	localparam int TRAILER_LEN = 8;
	localparam int FILL_W      = $clog2(TRAILER_LEN + 1);
	localparam int IDX_W       = $clog2(TRAILER_LEN);

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_LC_A = 8'h61;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// results caused by one item: n_bytes payload bytes, then an optional verdict
	typedef struct packed {
		logic [TRAILER_LEN-1:0][7:0] bytes;
		logic [FILL_W-1:0]           n_bytes;
		logic                        verdict;
		logic                        ok;
	} res_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = ASCII_ZERO + {4'h0, nib};
		end else begin
			r = ASCII_LC_A + {4'h0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

### rtl/hxt_core.sv
// hxt_core: trailer window, running CRC and per-frame state; builds the
// result set for the item in the input register. Depends on hxt_pkg.

module hxt_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [7:0]     data_byte,
	input  logic           frame_end,
	input  logic           check_enable,
	output hxt_pkg::res_t  res
);
	import hxt_pkg::*;

	logic [31:0]                 crc_q;
	logic [TRAILER_LEN-1:0][7:0] win_q;
	logic [FILL_W-1:0]           fill_q;
	logic                        frame_open_q;
	logic                        frame_check_q;

	logic                        eff_check;
	logic                        pop;
	logic [7:0]                  old_byte;
	logic [31:0]                 crc_nx;
	logic [31:0]                 crc_val;
	logic [TRAILER_LEN-1:0][7:0] win_nx;
	logic [FILL_W-1:0]           fill_nx;
	logic                        match;

	assign eff_check = frame_open_q ? frame_check_q : check_enable;
	assign pop       = (fill_q == FILL_W'(TRAILER_LEN));
	assign old_byte  = win_q[0];
	assign crc_nx    = pop ? crc_byte(crc_q, old_byte) : crc_q;
	assign crc_val   = ~crc_nx;
	assign fill_nx   = pop ? fill_q : fill_q + FILL_W'(1);

	always_comb begin
		for (int i = 0; i < TRAILER_LEN - 1; i++) begin
			if (pop) begin
				win_nx[i] = win_q[i+1];
			end else begin
				win_nx[i] = (fill_q[IDX_W-1:0] == IDX_W'(i)) ? data_byte : win_q[i];
			end
		end
		if (pop || fill_q[IDX_W-1:0] == IDX_W'(TRAILER_LEN - 1)) begin
			win_nx[TRAILER_LEN-1] = data_byte;
		end else begin
			win_nx[TRAILER_LEN-1] = win_q[TRAILER_LEN-1];
		end
	end

	// most significant nibble sits in the oldest window entry
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < TRAILER_LEN; i++) begin
			if (hex_char(crc_val[(TRAILER_LEN-1-i)*4 +: 4]) != win_nx[i]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		res         = '0;
		res.bytes   = win_nx;
		if (!eff_check) begin
			res.bytes[0] = data_byte;
			res.n_bytes  = FILL_W'(1);
			res.verdict  = frame_end;
			res.ok       = 1'b1;
		end else if (pop) begin
			res.bytes[0] = old_byte;
			res.n_bytes  = FILL_W'(1);
			res.verdict  = frame_end;
			res.ok       = match;
		end else if (frame_end) begin
			if (fill_nx == FILL_W'(TRAILER_LEN)) begin
				res.n_bytes = '0;
				res.ok      = match;
			end else begin
				res.n_bytes = fill_nx;
				res.ok      = 1'b1;
			end
			res.verdict = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q         <= CRC_INIT;
			fill_q        <= '0;
			frame_open_q  <= 1'b0;
			frame_check_q <= 1'b0;
		end else if (advance) begin
			if (frame_end) begin
				crc_q         <= CRC_INIT;
				fill_q        <= '0;
				frame_open_q  <= 1'b0;
				frame_check_q <= 1'b0;
			end else begin
				frame_open_q  <= 1'b1;
				frame_check_q <= eff_check;
				if (eff_check) begin
					crc_q  <= crc_nx;
					fill_q <= fill_nx;
				end
			end
		end
	end

	// window entries past fill_q are never read
	always_ff @(posedge clk) begin
		if (advance && eff_check && !frame_end) begin
			win_q <= win_nx;
		end
	end

endmodule

### rtl/hxt_outq.sv
// hxt_outq: result register that holds one item's result set and releases
// it one result per cycle while m_tready is high. Depends on hxt_pkg.

module hxt_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  hxt_pkg::res_t  res,
	output logic           can_load,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata,
	output logic           m_tuser,
	output logic           m_tlast
);
	import hxt_pkg::*;

	logic [TRAILER_LEN-1:0][7:0] buf_q;
	logic [FILL_W-1:0]           rem_q;
	logic                        vpend_q;
	logic                        ok_q;
	logic                        have_byte;
	logic                        one_left;
	logic                        pop;

	assign have_byte = (rem_q != '0);
	assign one_left  = have_byte ? (rem_q == FILL_W'(1) && !vpend_q) : vpend_q;
	assign m_tvalid  = have_byte || vpend_q;
	assign pop       = m_tvalid && m_tready;
	assign can_load  = !m_tvalid || (pop && one_left);

	always_comb begin
		if (have_byte) begin
			m_tuser = KIND_PAYLOAD;
			m_tdata = {7'h0, 1'b0, buf_q[0]};
			m_tlast = one_left;
		end else begin
			m_tuser = KIND_VERDICT;
			m_tdata = {7'h0, ok_q, 8'h00};
			m_tlast = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			vpend_q <= 1'b0;
		end else if (load) begin
			rem_q   <= res.n_bytes;
			vpend_q <= res.verdict;
		end else if (pop) begin
			if (have_byte) begin
				rem_q <= rem_q - FILL_W'(1);
			end else begin
				vpend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.bytes;
			ok_q  <= res.ok;
		end else if (pop && have_byte) begin
			buf_q <= {8'h00, buf_q[TRAILER_LEN-1:1]};
		end
	end

endmodule

### rtl/crc32_hex_trailer_checker_top.sv
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata[7:0] data_byte, s_tlast frame_end
// m       | out | m_tvalid/m_tready  | m_tdata[7:0] payload_byte, [8] crc_ok; m_tuser item_kind;
//         |     |                    | m_tlast run_last
// cfg     | in  | cfg_wr_en          | cfg_wr_data check_enable
//
// One item per cycle when each item yields at most one result and m_tready
// stays high; an accepted item passes from the input register into the output
// register. A short frame's final item releases up to eight results, one per
// cycle while m_tready is high, and input waits while they drain. Reset clears
// the frame state and sets check_enable. m_tready low holds the current result
// and backs up through the input register to s_tready. Depends on hxt_pkg, hxt_core, hxt_outq.

module crc32_hex_trailer_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload_byte, [8] crc_ok, [15:9] zero
	output logic        m_tuser,   // [0] item_kind
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);
	import hxt_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       check_enable_q;
	logic       can_load;
	logic       advance;
	res_t       res;

	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			check_enable_q <= 1'b1;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (cfg_wr_en) begin
				check_enable_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hxt_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.data_byte    (byte_s1),
		.frame_end    (last_s1),
		.check_enable (check_enable_q),
		.res          (res)
	);

	hxt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/hxt_checker.sv
// hxt_checker: port-level checks on the result stream of the trailer checker,
// bound to crc32_hex_trailer_checker_top. Depends on hxt_pkg.

module hxt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import hxt_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_VERDICT |-> m_tlast)
		else $error("verdict not last of its run");

	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_VERDICT |-> m_tdata[7:0] == 8'h00)
		else $error("verdict carries payload byte");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAYLOAD |-> !m_tdata[8])
		else $error("payload item with crc_ok set");

endmodule

bind crc32_hex_trailer_checker_top hxt_checker u_hxt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

### dv/crc32_hex_trailer_checker_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for crc32_hex_trailer_checker_top: byte frames with
// CRC-32 hex trailers, a verdict predictor in a small class, random stalls.
// Depends on hxt_pkg and the checker RTL.

module crc32_hex_trailer_checker_top_tb;
	import hxt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic       kind;
		logic [7:0] data;
		logic       ok;
		logic       last;
	} verdict_item_t;

	class frame_verdict_board;
		verdict_item_t pending_results[$];
		logic          check_en;
		logic          frame_open;
		logic          frame_check;
		logic [31:0]   crc;
		logic [7:0]    win[TRAILER_LEN];
		int            fill;
		int            errors;

		function new();
			check_en = 1'b1;
			errors   = 0;
			clear_frame();
		endfunction

		static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			logic        fb;
			r = c;
			for (int k = 0; k < 8; k++) begin
				fb = r[0] ^ b[k];
				r  = r >> 1;
				if (fb) begin
					r = r ^ CRC_POLY;
				end
			end
			return r;
		endfunction

		static function logic [7:0] nibble_ascii(logic [3:0] n);
			return (n > 4'd9) ? (8'h57 + {4'h0, n}) : (8'h30 + {4'h0, n});
		endfunction

		function void clear_frame();
			crc         = 32'hFFFF_FFFF;
			fill        = 0;
			frame_open  = 1'b0;
			frame_check = 1'b0;
			foreach (win[i]) win[i] = 8'h00;
		endfunction

		function void add(ref verdict_item_t q[$], input logic kind, input logic [7:0] data,
				input logic ok);
			verdict_item_t it;
			it.kind = kind;
			it.data = data;
			it.ok   = ok;
			it.last = 1'b0;
			q.push_back(it);
		endfunction

		function void accept_byte(logic [7:0] b, logic last);
			verdict_item_t fresh[$];
			logic [31:0]   v;
			logic          ok;
			if (!frame_open) begin
				frame_open  = 1'b1;
				frame_check = check_en;
			end
			if (!frame_check) begin
				add(fresh, KIND_PAYLOAD, b, 1'b0);
				if (last) begin
					add(fresh, KIND_VERDICT, 8'h00, 1'b1);
					clear_frame();
				end
			end else begin
				if (fill >= TRAILER_LEN) begin
					crc = crc_next(crc, win[0]);
					add(fresh, KIND_PAYLOAD, win[0], 1'b0);
					for (int i = 0; i < TRAILER_LEN - 1; i++) win[i] = win[i+1];
					win[TRAILER_LEN-1] = b;
				end else begin
					win[fill] = b;
					fill++;
				end
				if (last) begin
					ok = 1'b1;
					if (fill < TRAILER_LEN) begin
						for (int i = 0; i < fill; i++) add(fresh, KIND_PAYLOAD, win[i], 1'b0);
					end else begin
						v = ~crc;
						for (int i = 0; i < TRAILER_LEN; i++) begin
							if (nibble_ascii(v[31-4*i -: 4]) != win[i]) begin
								ok = 1'b0;
							end
						end
					end
					add(fresh, KIND_VERDICT, 8'h00, ok);
					clear_frame();
				end
			end
			if (fresh.size() > 0) begin
				fresh[fresh.size()-1].last = 1'b1;
			end
			foreach (fresh[i]) pending_results.push_back(fresh[i]);
		endfunction

		function void match_result(logic [15:0] tdata, logic tuser, logic tlast);
			verdict_item_t exp_item;
			logic [15:0]   exp_data;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
					$time, tdata, tuser, tlast);
				errors++;
				return;
			end
			exp_item = pending_results.pop_front();
			exp_data = {7'h00, exp_item.ok, exp_item.data};
			if (tdata !== exp_data) begin
				$display("%0t: tdata mismatch expected %h actual %h", $time, exp_data, tdata);
				errors++;
			end
			if (tuser !== exp_item.kind) begin
				$display("%0t: tuser mismatch expected %b actual %b", $time, exp_item.kind, tuser);
				errors++;
			end
			if (tlast !== exp_item.last) begin
				$display("%0t: tlast mismatch expected %b actual %b", $time, exp_item.last, tlast);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_wr_en;
	logic        cfg_wr_data;

	frame_verdict_board board;
	int                 items_sent;
	int                 cycle_count;
	logic               quiet_in;
	logic               quiet_out;
	logic [7:0]         frame_bytes[$];

	crc32_hex_trailer_checker_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		board.accept_byte(b, last);
		items_sent++;
	endtask

	task automatic set_check_enable(input logic v);
		s_tvalid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en      <= 1'b0;
		board.check_en  = v;
	endtask

	// payload followed by its correct hex trailer
	task automatic build_good_frame(input int plen);
		logic [31:0] c;
		logic [7:0]  b;
		frame_bytes.delete();
		c = 32'hFFFF_FFFF;
		for (int i = 0; i < plen; i++) begin
			b = 8'($urandom_range(0, 255));
			frame_bytes.push_back(b);
			c = frame_verdict_board::crc_next(c, b);
		end
		c = ~c;
		for (int i = 0; i < TRAILER_LEN; i++) begin
			frame_bytes.push_back(frame_verdict_board::nibble_ascii(c[31-4*i -: 4]));
		end
	endtask

	task automatic send_frame(input logic allow_toggle);
		int split;
		split = -1;
		if (allow_toggle && frame_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
			split = $urandom_range(1, frame_bytes.size() - 1);
		end
		quiet_in = ($urandom_range(0, 3) == 0);
		foreach (frame_bytes[i]) begin
			if (i == split) begin
				set_check_enable(~board.check_en);
			end
			send_item(frame_bytes[i], i == frame_bytes.size() - 1);
		end
	endtask

	initial begin
		int kind_pick;
		int idx;
		logic [7:0] c;
		board       = new();
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		s_tlast     = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		items_sent  = 0;
		cycle_count = 0;
		quiet_in    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// trailer only: CRC of an empty payload
		build_good_frame(0);
		send_frame(1'b0);
		frame_bytes = {8'hFF};
		send_frame(1'b0);
		build_good_frame(1);
		frame_bytes[0] = 8'h00;
		frame_bytes = frame_bytes[0:0];
		begin
			logic [31:0] z;
			z = ~frame_verdict_board::crc_next(32'hFFFF_FFFF, 8'h00);
			for (int i = 0; i < TRAILER_LEN; i++) begin
				frame_bytes.push_back(frame_verdict_board::nibble_ascii(z[31-4*i -: 4]));
			end
		end
		send_frame(1'b0);
		frame_bytes = {8'h00, 8'hFF, 8'h80};
		send_frame(1'b0);
		set_check_enable(1'b0);
		frame_bytes = {8'hFF, 8'h00};
		send_frame(1'b0);
		frame_bytes = {8'h5A};
		send_frame(1'b0);
		set_check_enable(1'b1);

		while (items_sent < 305) begin
			if ($urandom_range(0, 7) == 0) begin
				set_check_enable(1'($urandom_range(0, 1)));
			end
			kind_pick = $urandom_range(0, 99);
			if (kind_pick < 75) begin
				build_good_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12));
				if (kind_pick >= 60) begin
					idx = frame_bytes.size() - TRAILER_LEN + $urandom_range(0, 7);
					c   = frame_bytes[idx];
					if (c >= 8'h61 && $urandom_range(0, 1) == 1) begin
						frame_bytes[idx] = c ^ 8'h20;
					end else begin
						frame_bytes[idx] = c ^ 8'($urandom_range(1, 255));
					end
				end
			end else begin
				frame_bytes.delete();
				repeat ((kind_pick < 88) ? $urandom_range(1, 7) : $urandom_range(8, 16)) begin
					frame_bytes.push_back(8'($urandom_range(0, 255)));
				end
			end
			send_frame(1'b1);
		end

		s_tvalid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		int stall;
		int taken;
		m_tready  = 1'b0;
		quiet_out = 1'b0;
		taken     = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 40 == 0) begin
				quiet_out = ($urandom_range(0, 3) == 0);
			end
			stall = quiet_out ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.match_result(m_tdata, m_tuser, m_tlast);
			taken++;
		end
	end

endmodule
